[rtl/rllh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllh_pkg
// Shared codes, widths and the command and status bundles between the
// controller and the datapath of the request latency histogram.
// ----------------------------------------------------------------------------
`default_nettype none

package rllh_pkg;

  localparam logic [1:0] FUNC_ISSUE    = 2'd0;
  localparam logic [1:0] FUNC_COMPLETE = 2'd1;

  localparam logic [1:0] ST_ISSUED   = 2'd0;
  localparam logic [1:0] ST_RECORDED = 2'd1;
  localparam logic [1:0] ST_IGNORED  = 2'd2;
  localparam logic [1:0] ST_READ     = 2'd3;

  localparam int TIME_W    = 64;
  localparam int TAG_IN_W  = 8;
  localparam int TAG_MAX_W = 16;
  localparam int RB_W      = 5;
  localparam int BKT_OUT_W = 5;
  localparam int BKT_EXT_W = 7;
  localparam int US_DIV    = 1000;

  typedef struct packed {
    logic       clr;
    logic       load;
    logic       rd;
    logic       wr_issue;
    logic       calc_diff;
    logic       calc_msb;
    logic       calc_bin;
    logic       wr_inc;
    logic       emit;
    logic [1:0] emit_status;
  } rllh_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       out_free;
    logic       tag_hit;
    logic [1:0] func;
  } rllh_sts_t;

endpackage

`default_nettype wire

[rtl/request_latency_log2_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// request_latency_log2_histogram
// Tracks outstanding requests by tag and bins completion latencies into a
// log2 microsecond histogram that can be read back bucket by bucket.
//
//   Channel  Direction  tdata                           tuser
//   in_      input      request_tag, now_ns, read_bucket func
//   out_     output     bucket, count                   status
//
// Issue, read and completion of an unknown tag pass through the IDLE, RD and
// LOOK states; a recorded completion also passes through MSB, BIN and INC, set
// by the registered reads of the tag table and the histogram and the three-step
// binning sequence. After reset both tables are cleared by a sweep over
// max(2^TAG_BITS, NUM_BUCKETS) addresses, during which in_tready stays low.
// A result held in the output register does not block the next input beat;
// only the hand-off of the following result waits for out_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module request_latency_log2_histogram #(
  parameter int TAG_BITS    = 8,
  parameter int NUM_BUCKETS = 26
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // request_tag[7:0], now_ns[71:8], read_bucket[76:72]
  input  wire logic [1:0]  in_tuser,   // func[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,  // bucket[4:0], count[68:5]
  output logic [1:0]       out_tuser   // status[1:0]
);

  rllh_pkg::rllh_cmd_t cmd;
  rllh_pkg::rllh_sts_t sts;

  rllh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rllh_dp #(
    .TAG_BITS    (TAG_BITS),
    .NUM_BUCKETS (NUM_BUCKETS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_tready)
    else $error("input ready during the clearing sweep");

  a_emit_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result written over an untaken result");

  a_one_beat_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second beat accepted while one is in flight");

endmodule

`default_nettype wire

[rtl/rllh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllh_ram
// Generic simple dual-port RAM with one write port and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rllh_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[rtl/rllh_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllh_dp
// Datapath: input latch, tag table, histogram table, latency binning,
// clearing sweep counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rllh_dp #(
  parameter int TAG_BITS    = 8,
  parameter int NUM_BUCKETS = 26
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [79:0]       in_tdata,
  input  wire logic [1:0]        in_tuser,
  input  wire logic              out_tready,
  output logic                   out_tvalid,
  output logic [71:0]            out_tdata,
  output logic [1:0]             out_tuser,
  input  wire rllh_pkg::rllh_cmd_t cmd,
  output rllh_pkg::rllh_sts_t    sts
);

  localparam int TW        = rllh_pkg::TIME_W;
  localparam int TAG_DEPTH = 1 << TAG_BITS;
  localparam int BKT_W     = $clog2(NUM_BUCKETS);
  localparam int SWP_LEN   = (TAG_DEPTH > NUM_BUCKETS) ? TAG_DEPTH : NUM_BUCKETS;
  localparam int SWP_W     = $clog2(SWP_LEN);
  localparam int EW        = rllh_pkg::BKT_EXT_W;

  function automatic logic [5:0] msb_pos(input logic [TW-1:0] v);
    logic [5:0] pos;
    pos = '0;
    for (int i = 0; i < TW; i++) begin
      if (v[i]) begin
        pos = 6'(i);
      end
    end
    return pos;
  endfunction

  logic [1:0]                     func_r;
  logic [rllh_pkg::TAG_IN_W-1:0]  tag_r;
  logic [TW-1:0]                  now_r;
  logic [rllh_pkg::RB_W-1:0]      rb_r;
  logic [TW-1:0]                  diff_r;
  logic [5:0]                     p_r;
  logic [BKT_W-1:0]               bucket_r;
  logic [SWP_W-1:0]               swp_cnt_r;
  logic [SWP_W-1:0]               swp_cnt_nxt;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic [1:0]                     out_status_r;
  logic [rllh_pkg::BKT_OUT_W-1:0] out_bucket_r;
  logic [TW-1:0]                  out_count_r;

  logic [rllh_pkg::TAG_MAX_W-1:0] tag_ext;
  logic [TAG_BITS-1:0]            tag_idx;
  logic [EW-1:0]                  rb_ext;
  logic [BKT_W-1:0]               rb_idx;
  logic                           rb_ok;
  logic                           swp_in_tag;
  logic                           swp_in_bkt;

  logic                           tag_wr_en;
  logic [TAG_BITS-1:0]            tag_wr_addr;
  logic [TW:0]                    tag_wr_data;
  logic [TW:0]                    tag_rdata;

  logic                           bkt_wr_en;
  logic [BKT_W-1:0]               bkt_wr_addr;
  logic [TW-1:0]                  bkt_wr_data;
  logic                           bkt_rd_en;
  logic [BKT_W-1:0]               bkt_rd_addr;
  logic [TW-1:0]                  bkt_rdata;
  logic [TW-1:0]                  cnt_inc;

  logic [TW-1:0]                  thr;
  logic                           bump;
  logic [EW-1:0]                  t_ext;
  logic [EW-1:0]                  raw_ext;
  logic [EW-1:0]                  clamp_ext;
  logic [BKT_W-1:0]               bkt_calc;
  logic [EW-1:0]                  bucket_ext;

  logic [rllh_pkg::BKT_OUT_W-1:0] emit_bucket;
  logic [TW-1:0]                  emit_count;

  assign tag_ext    = rllh_pkg::TAG_MAX_W'(tag_r);
  assign tag_idx    = tag_ext[TAG_BITS-1:0];
  assign rb_ext     = EW'(rb_r);
  assign rb_idx     = rb_ext[BKT_W-1:0];
  assign rb_ok      = rb_ext < EW'(NUM_BUCKETS);
  assign swp_in_tag = {1'b0, swp_cnt_r} < (SWP_W+1)'(TAG_DEPTH);
  assign swp_in_bkt = {1'b0, swp_cnt_r} < (SWP_W+1)'(NUM_BUCKETS);

  // A latency of d ns has its top set bit at p, so floor(log2(d / 1000)) is
  // p - 10, or p - 9 when d reaches 1000 shifted left by p - 9.
  assign thr       = TW'(rllh_pkg::US_DIV) << (p_r - 6'd9);
  assign bump      = (p_r >= 6'd9) && (diff_r >= thr);
  assign t_ext     = EW'(p_r) - EW'(9) + EW'(bump);
  assign raw_ext   = ((p_r < 6'd9) || (t_ext == '0)) ? '0 : (t_ext - EW'(1));
  assign clamp_ext = (raw_ext >= EW'(NUM_BUCKETS)) ? EW'(NUM_BUCKETS - 1) : raw_ext;
  assign bkt_calc  = clamp_ext[BKT_W-1:0];

  assign tag_wr_en   = (cmd.clr && swp_in_tag) || cmd.wr_issue || cmd.calc_bin;
  assign tag_wr_addr = cmd.clr ? swp_cnt_r[TAG_BITS-1:0] : tag_idx;
  assign tag_wr_data = cmd.wr_issue ? {1'b1, now_r} : '0;

  assign cnt_inc     = bkt_rdata + TW'(1);
  assign bkt_wr_en   = (cmd.clr && swp_in_bkt) || cmd.wr_inc;
  assign bkt_wr_addr = cmd.clr ? swp_cnt_r[BKT_W-1:0] : bucket_r;
  assign bkt_wr_data = cmd.clr ? '0 : cnt_inc;
  assign bkt_rd_en   = cmd.rd || cmd.calc_bin;
  assign bkt_rd_addr = cmd.calc_bin ? bkt_calc : rb_idx;

  rllh_ram #(
    .WIDTH (TW + 1),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_wr_en),
    .wr_addr (tag_wr_addr),
    .wr_data (tag_wr_data),
    .rd_en   (cmd.rd),
    .rd_addr (tag_idx),
    .rd_data (tag_rdata)
  );

  rllh_ram #(
    .WIDTH (TW),
    .DEPTH (NUM_BUCKETS)
  ) u_bkt_ram (
    .clk     (clk),
    .wr_en   (bkt_wr_en),
    .wr_addr (bkt_wr_addr),
    .wr_data (bkt_wr_data),
    .rd_en   (bkt_rd_en),
    .rd_addr (bkt_rd_addr),
    .rd_data (bkt_rdata)
  );

  assign bucket_ext = EW'(bucket_r);

  always_comb begin
    unique case (cmd.emit_status)
      rllh_pkg::ST_RECORDED: begin
        emit_bucket = bucket_ext[rllh_pkg::BKT_OUT_W-1:0];
        emit_count  = cnt_inc;
      end
      rllh_pkg::ST_READ: begin
        emit_bucket = rb_r;
        emit_count  = rb_ok ? bkt_rdata : '0;
      end
      rllh_pkg::ST_ISSUED, rllh_pkg::ST_IGNORED: begin
        emit_bucket = '0;
        emit_count  = '0;
      end
    endcase
  end

  assign swp_cnt_nxt   = cmd.clr ? (swp_cnt_r + SWP_W'(1)) : swp_cnt_r;
  assign out_valid_nxt = cmd.emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swp_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      swp_cnt_r   <= swp_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_tuser;
      tag_r  <= in_tdata[7:0];
      now_r  <= in_tdata[71:8];
      rb_r   <= in_tdata[76:72];
    end
    if (cmd.calc_diff) begin
      diff_r <= now_r - tag_rdata[TW-1:0];
    end
    if (cmd.calc_msb) begin
      p_r <= msb_pos(diff_r);
    end
    if (cmd.calc_bin) begin
      bucket_r <= bkt_calc;
    end
    if (cmd.emit) begin
      out_status_r <= cmd.emit_status;
      out_bucket_r <= emit_bucket;
      out_count_r  <= emit_count;
    end
  end

  assign sts.clr_done = (swp_cnt_r == SWP_W'(SWP_LEN - 1));
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.tag_hit  = tag_rdata[TW];
  assign sts.func     = func_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_bucket_r};
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

[rtl/rllh_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rllh_ctrl
// Controller: sequences the clearing sweep and each beat through table
// lookup, latency binning, counter update and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module rllh_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire rllh_pkg::rllh_sts_t sts,
  output rllh_pkg::rllh_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_RD,
    S_LOOK,
    S_MSB,
    S_BIN,
    S_INC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_SWEEP: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_LOOK;
      end
      S_LOOK: begin
        priority if (sts.func == rllh_pkg::FUNC_ISSUE) begin
          if (sts.out_free) begin
            cmd.wr_issue    = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_status = rllh_pkg::ST_ISSUED;
            state_nxt       = S_IDLE;
          end
        end else if (sts.func == rllh_pkg::FUNC_COMPLETE) begin
          if (sts.tag_hit) begin
            cmd.calc_diff = 1'b1;
            state_nxt     = S_MSB;
          end else if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = rllh_pkg::ST_IGNORED;
            state_nxt       = S_IDLE;
          end
        end else begin
          if (sts.out_free) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = rllh_pkg::ST_READ;
            state_nxt       = S_IDLE;
          end
        end
      end
      S_MSB: begin
        cmd.calc_msb = 1'b1;
        state_nxt    = S_BIN;
      end
      S_BIN: begin
        cmd.calc_bin = 1'b1;
        state_nxt    = S_INC;
      end
      S_INC: begin
        if (sts.out_free) begin
          cmd.wr_inc      = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = rllh_pkg::ST_RECORDED;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[dv/tb_request_latency_log2_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_request_latency_log2_histogram
// Self-checking bench for the request latency histogram. A directed table
// covers the read, issue and completion corner cases. A random phase follows
// in which most beats are issue and completion pairs with latencies spread
// over every log2 bin. Each accepted input beat updates a local tag table and
// histogram that predict the result beat, and result beats are compared field
// by field in order. Both channels idle at random, and once the result side
// holds off long enough for the block to stall its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_request_latency_log2_histogram;

  localparam logic [1:0] FUNC_READ     = 2'd2;
  localparam logic [1:0] FUNC_READ_ALT = 2'd3;
  localparam int NUM_BKT      = 26;
  localparam int TAG_DEPTH    = 256;
  localparam int RANDOM_ITEMS = 927;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_SHOWN    = 10;
  localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  bkt;
    logic [63:0] cnt;
  } hist_result_t;

  typedef struct packed {
    logic [1:0]   fn;
    logic [7:0]   tag;
    logic [63:0]  now;
    logic [4:0]   rb;
    bit           fixed;
    hist_result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{FUNC_READ,                8'd0,   64'd0,    5'd0,  1'b1,
      '{rllh_pkg::ST_READ, 5'd0, 64'd0}},
    '{FUNC_READ,                8'd0,   64'd0,    5'd25, 1'b1,
      '{rllh_pkg::ST_READ, 5'd25, 64'd0}},
    '{FUNC_READ,                8'd255, ALL_ONES, 5'd31, 1'b1,
      '{rllh_pkg::ST_READ, 5'd31, 64'd0}},
    '{FUNC_READ_ALT,            8'd0,   64'd0,    5'd26, 1'b1,
      '{rllh_pkg::ST_READ, 5'd26, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd0,   64'd0,    5'd0,  1'b1,
      '{rllh_pkg::ST_IGNORED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd255, ALL_ONES, 5'd31, 1'b1,
      '{rllh_pkg::ST_IGNORED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_ISSUE,     8'd0,   64'd0,    5'd0,  1'b1,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd0,   64'd999,  5'd0,  1'b1,
      '{rllh_pkg::ST_RECORDED, 5'd0, 64'd1}},
    '{rllh_pkg::FUNC_ISSUE,     8'd255, 64'd1000, 5'd31, 1'b1,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd255, 64'd2999, 5'd0,  1'b0,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_ISSUE,     8'd1,   ALL_ONES, 5'd0,  1'b1,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd1,   ALL_ONES - 64'd1, 5'd0, 1'b0,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_ISSUE,     8'd2,   64'd100,  5'd31, 1'b1,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_ISSUE,     8'd2,   64'd5000, 5'd0,  1'b1,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd2,   64'd9000, 5'd0,  1'b0,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd2,   64'd9000, 5'd0,  1'b1,
      '{rllh_pkg::ST_IGNORED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_ISSUE,     8'd3,   64'd0,    5'd0,  1'b1,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd3,   64'h8000_0000_0000_0000, 5'd0, 1'b0,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_ISSUE,     8'd170, 64'd12345, 5'd0, 1'b1,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{rllh_pkg::FUNC_COMPLETE,  8'd170, 64'd14345, 5'd0, 1'b0,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{FUNC_READ,                8'd0,   64'd0,    5'd0,  1'b0,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{FUNC_READ,                8'd0,   64'd0,    5'd25, 1'b0,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}},
    '{FUNC_READ_ALT,            8'd255, ALL_ONES, 5'd2,  1'b0,
      '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  logic [63:0] start_ns [TAG_DEPTH];
  bit          tag_open [TAG_DEPTH];
  logic [63:0] bin_total [NUM_BKT];

  hist_result_t latency_results_q [$];
  int          errs;
  int          cycles;
  bit          calm_in;
  bit          hold_go;
  bit          hold_active;

  request_latency_log2_histogram i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic hist_result_t bin_latency_event(input logic [1:0] fn,
                                                     input logic [7:0] tag,
                                                     input logic [63:0] now,
                                                     input logic [4:0] rb);
    hist_result_t r;
    logic [63:0]  us;
    int           b;
    r = '{rllh_pkg::ST_ISSUED, 5'd0, 64'd0};
    case (fn)
      rllh_pkg::FUNC_ISSUE: begin
        start_ns[tag] = now;
        tag_open[tag] = 1'b1;
      end
      rllh_pkg::FUNC_COMPLETE: begin
        if (tag_open[tag]) begin
          us = (now - start_ns[tag]) / rllh_pkg::US_DIV;
          b = 0;
          for (int i = 0; i < 64; i++) begin
            if (us[i]) begin
              b = i;
            end
          end
          if (b > NUM_BKT - 1) begin
            b = NUM_BKT - 1;
          end
          bin_total[b] = bin_total[b] + 64'd1;
          tag_open[tag] = 1'b0;
          r = '{rllh_pkg::ST_RECORDED, 5'(b), bin_total[b]};
        end else begin
          r.status = rllh_pkg::ST_IGNORED;
        end
      end
      default: begin
        r.status = rllh_pkg::ST_READ;
        r.bkt = rb;
        if (rb < NUM_BKT) begin
          r.cnt = bin_total[rb];
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(input logic [1:0] fn, input logic [7:0] tag,
                           input logic [63:0] now, input logic [4:0] rb,
                           input bit fixed, input hist_result_t typed);
    hist_result_t pred;
    int           gap;
    gap = (calm_in || hold_active) ? 0 : $urandom_range(0, 16);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= fn;
    in_tdata  <= {3'b000, rb, now, tag};
    do @(posedge clk); while (!in_tready);
    pred = bin_latency_event(fn, tag, now, rb);
    latency_results_q.push_back(fixed ? typed : pred);
  endtask

  // A long result-side hold once the random phase is under way.
  initial begin
    hold_active = 1'b0;
    wait (hold_go);
    @(posedge clk);
    hold_active <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active <= 1'b0;
  end

  initial begin
    hist_result_t want;
    hist_result_t got;
    int           stall;
    int           n;
    n = 0;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = ((n / 50) % 4 == 1) ? 0 : $urandom_range(0, 16);
      if (stall > 0 || hold_active) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
        while (hold_active) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      n++;
      got = '{out_tuser, out_tdata[4:0], out_tdata[68:5]};
      if (latency_results_q.size() == 0) begin
        errs++;
        if (errs <= MAX_SHOWN) begin
          $display("[%0t] result beat with nothing pending: status %0d bucket %0d count %0d",
                   $realtime, got.status, got.bkt, got.cnt);
        end
      end else begin
        want = latency_results_q.pop_front();
        if (got !== want) begin
          errs++;
          if (errs <= MAX_SHOWN) begin
            $display("[%0t] result mismatch: status %0d/%0d bucket %0d/%0d count %0d/%0d",
                     $realtime, want.status, got.status, want.bkt, got.bkt,
                     want.cnt, got.cnt);
          end
        end
      end
    end
  end

  initial begin
    logic [1:0]   fn;
    logic [7:0]   tag;
    logic [63:0]  now;
    logic [4:0]   rb;
    logic [63:0]  lat;
    logic [7:0]   open_tags [$];
    int           pick;
    errs = 0;
    cycles = 0;
    calm_in = 1'b0;
    hold_go = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    for (int i = 0; i < TAG_DEPTH; i++) begin
      start_ns[i] = '0;
      tag_open[i] = 1'b0;
    end
    for (int i = 0; i < NUM_BKT; i++) begin
      bin_total[i] = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].fn, dir_rows[i].tag, dir_rows[i].now, dir_rows[i].rb,
                dir_rows[i].fixed, dir_rows[i].res);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm_in = ((i / 40) % 3 == 2);
      if (i == HOLD_AT) begin
        hold_go = 1'b1;
      end
      tag = 8'($urandom);
      now = {$urandom, $urandom};
      rb = 5'($urandom_range(0, 31));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        fn = rllh_pkg::FUNC_ISSUE;
      end else if (pick < 82) begin
        fn = rllh_pkg::FUNC_COMPLETE;
        open_tags.delete();
        for (int t = 0; t < TAG_DEPTH; t++) begin
          if (tag_open[t]) begin
            open_tags.push_back(8'(t));
          end
        end
        if (open_tags.size() != 0 && $urandom_range(0, 9) != 0) begin
          tag = open_tags[$urandom_range(0, open_tags.size() - 1)];
          lat = {$urandom, $urandom} >> $urandom_range(0, 63);
          now = start_ns[tag] + lat;
        end
      end else begin
        fn = ($urandom_range(0, 3) == 0) ? FUNC_READ_ALT : FUNC_READ;
      end
      send_item(fn, tag, now, rb, 1'b0, '0);
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    while (latency_results_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errs == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
